// ===== rtl/bsc_pkg.sv =====
// Shared types and constants for the bounded-spread run counter.
`timescale 1ns / 1ps
package bsc_pkg;
    localparam int MAX_LEN_DEF = 4096;
    localparam int SAMPLE_W    = 32;
    localparam int TOTAL_W     = 24;
    localparam int LEN_W       = 13;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAXPOP,
        ST_MINPOP,
        ST_SHRINK,
        ST_HEADS,
        ST_DONE
    } t_state;
endpackage

// ===== rtl/bsc_front.sv =====
// Input stage: two-entry queue holding accepted transactions for the back end.
`timescale 1ns / 1ps
module bsc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bsc_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output bsc_pkg::t_item o_item
);
    bsc_pkg::t_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_take;
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/bsc_back.sv =====
// Back end: monotonic max and min queues with a sliding window start.
`timescale 1ns / 1ps
module bsc_back #(
    parameter int MAX_LEN = bsc_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [31:0]                  i_spread_limit,
    input  logic                         i_valid,
    output logic                         o_take,
    input  bsc_pkg::t_item               i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bsc_pkg::TOTAL_W-1:0]  o_total,
    output logic [bsc_pkg::LEN_W-1:0]    o_len,
    output logic                         o_ovf
);
    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int DW = bsc_pkg::SAMPLE_W + AW;

    logic [DW-1:0] r_maxq [MAX_LEN];
    logic [DW-1:0] r_minq [MAX_LEN];
    logic [DW-1:0] r_maxrd, r_minrd;

    bsc_pkg::t_state r_st, n_st;
    logic [PW-1:0] r_maxh, n_maxh, r_maxt, n_maxt, r_minh, n_minh, r_mint, n_mint;
    logic [PW-1:0] r_ws, n_ws, r_seen, n_seen;
    logic [bsc_pkg::TOTAL_W-1:0] r_tot, n_tot;
    logic r_ovf, n_ovf, r_last, n_last;
    logic signed [bsc_pkg::SAMPLE_W-1:0] r_v, n_v;
    logic r_oval, n_oval;
    logic [bsc_pkg::TOTAL_W-1:0] r_otot, n_otot;
    logic [bsc_pkg::LEN_W-1:0] r_olen, n_olen;
    logic r_oovf, n_oovf;
    logic [AW-1:0] maxra, minra;
    logic maxwe, minwe;
    logic signed [bsc_pkg::SAMPLE_W-1:0] maxv, minv;
    logic [AW-1:0] maxp, minp;
    logic signed [bsc_pkg::SAMPLE_W:0] diff;
    logic [PW-1:0] pos;

    assign maxv = r_maxrd[DW-1:AW];
    assign maxp = r_maxrd[AW-1:0];
    assign minv = r_minrd[DW-1:AW];
    assign minp = r_minrd[AW-1:0];
    assign diff = {maxv[bsc_pkg::SAMPLE_W-1], maxv} - {minv[bsc_pkg::SAMPLE_W-1], minv};
    assign pos = r_seen;

    assign o_valid = r_oval;
    assign o_total = r_otot;
    assign o_len = r_olen;
    assign o_ovf = r_oovf;

    always_ff @(posedge i_clk) begin
        if (maxwe) r_maxq[r_maxt[AW-1:0]] <= {r_v, pos[AW-1:0]};
        if (minwe) r_minq[r_mint[AW-1:0]] <= {r_v, pos[AW-1:0]};
        r_maxrd <= r_maxq[maxra];
        r_minrd <= r_minq[minra];
    end

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_last <= n_last;
        r_otot <= n_otot;
        r_olen <= n_olen;
        r_oovf <= n_oovf;
        if (!i_rst_n) begin
            r_st <= bsc_pkg::ST_IDLE;
            r_maxh <= '0; r_maxt <= '0; r_minh <= '0; r_mint <= '0;
            r_ws <= '0; r_seen <= '0; r_tot <= '0; r_ovf <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            r_st <= n_st;
            r_maxh <= n_maxh; r_maxt <= n_maxt; r_minh <= n_minh; r_mint <= n_mint;
            r_ws <= n_ws; r_seen <= n_seen; r_tot <= n_tot; r_ovf <= n_ovf;
            r_oval <= n_oval;
        end
    end

    always_comb begin
        n_st = r_st;
        n_maxh = r_maxh; n_maxt = r_maxt; n_minh = r_minh; n_mint = r_mint;
        n_ws = r_ws; n_seen = r_seen; n_tot = r_tot; n_ovf = r_ovf;
        n_v = r_v; n_last = r_last;
        n_oval = r_oval && !i_ready;
        n_otot = r_otot; n_olen = r_olen; n_oovf = r_oovf;
        o_take = 1'b0;
        maxwe = 1'b0; minwe = 1'b0;
        maxra = r_maxh[AW-1:0]; minra = r_minh[AW-1:0];
        unique case (r_st)
            bsc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_take = 1'b1;
                    n_v = i_item.value;
                    n_last = i_item.last;
                    if (r_seen < PW'(MAX_LEN)) begin
                        n_st = bsc_pkg::ST_MAXPOP;
                    end else begin
                        n_ovf = 1'b1;
                        n_st = i_item.last ? bsc_pkg::ST_DONE : bsc_pkg::ST_IDLE;
                    end
                end
                maxra = AW'(r_maxt - PW'(1));
                minra = AW'(r_mint - PW'(1));
            end
            bsc_pkg::ST_MAXPOP: begin
                // Read data holds the entry just below the tail.
                if (r_maxt > r_maxh && maxv <= r_v) begin
                    n_maxt = r_maxt - PW'(1);
                    maxra = AW'(r_maxt - PW'(2));
                end else begin
                    maxwe = 1'b1;
                    n_maxt = r_maxt + PW'(1);
                    n_st = bsc_pkg::ST_MINPOP;
                end
                minra = AW'(r_mint - PW'(1));
            end
            bsc_pkg::ST_MINPOP: begin
                if (r_mint > r_minh && minv >= r_v) begin
                    n_mint = r_mint - PW'(1);
                    minra = AW'(r_mint - PW'(2));
                end else begin
                    minwe = 1'b1;
                    n_mint = r_mint + PW'(1);
                    n_st = bsc_pkg::ST_HEADS;
                end
            end
            bsc_pkg::ST_HEADS: begin
                // Heads are read in this cycle; checked in the next.
                n_st = bsc_pkg::ST_SHRINK;
            end
            bsc_pkg::ST_SHRINK: begin
                if (diff > $signed({1'b0, i_spread_limit})) begin
                    // Advance the start to just past the older head.
                    if (maxp < minp) begin
                        n_ws = PW'(maxp) + PW'(1);
                        n_maxh = r_maxh + PW'(1);
                        maxra = AW'(r_maxh + PW'(1));
                    end else if (minp < maxp) begin
                        n_ws = PW'(minp) + PW'(1);
                        n_minh = r_minh + PW'(1);
                        minra = AW'(r_minh + PW'(1));
                    end else begin
                        n_ws = PW'(maxp) + PW'(1);
                        n_maxh = r_maxh + PW'(1);
                        n_minh = r_minh + PW'(1);
                        maxra = AW'(r_maxh + PW'(1));
                        minra = AW'(r_minh + PW'(1));
                    end
                end else begin
                    n_tot = r_tot + bsc_pkg::TOTAL_W'(pos - r_ws) + bsc_pkg::TOTAL_W'(1);
                    n_seen = r_seen + PW'(1);
                    n_st = r_last ? bsc_pkg::ST_DONE : bsc_pkg::ST_IDLE;
                end
            end
            bsc_pkg::ST_DONE: begin
                if (!r_oval || i_ready) begin
                    n_oval = 1'b1;
                    n_otot = r_tot;
                    n_olen = bsc_pkg::LEN_W'(r_seen);
                    n_oovf = r_ovf;
                    n_maxh = '0; n_maxt = '0; n_minh = '0; n_mint = '0;
                    n_ws = '0; n_seen = '0; n_tot = '0; n_ovf = 1'b0;
                    n_st = bsc_pkg::ST_IDLE;
                end
            end
            default: n_st = bsc_pkg::ST_IDLE;
        endcase
    end
endmodule

// ===== rtl/bounded_spread_subarray_counter.sv =====
// Top level of the bounded-spread run counter.
// In the back end each accepted sample is taken while the queue tails are read; entries
// are then popped from each monotonic queue and the new entry is written into each, the
// heads are reread, and heads are dropped from the window before the count is added.
// No new sample is taken until this is through. A sample past the length limit is
// dropped as it is taken. After a last sample the result register is loaded, which
// waits while the receiver holds off. An input queue of two transactions decouples
// the port.
`timescale 1ns / 1ps
module bounded_spread_subarray_counter #(
    parameter int MAX_LEN = bsc_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // sample_value
    input  logic        s_axis_tlast,  // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // run_total, sequence_length, overflowed, zero fill
    output logic        m_axis_tlast
);
    logic [31:0] r_limit;
    bsc_pkg::t_item in_item, q_item;
    logic q_valid, q_take;
    logic [bsc_pkg::TOTAL_W-1:0] tot;
    logic [bsc_pkg::LEN_W-1:0] len;
    logic ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= '0;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    assign in_item.value = s_axis_tdata;
    assign in_item.last = s_axis_tlast;

    bsc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_take(q_take), .o_item(q_item)
    );

    bsc_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_spread_limit(r_limit),
        .i_valid(q_valid), .o_take(q_take), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_total(tot), .o_len(len), .o_ovf(ovf)
    );

    assign m_axis_tdata = {2'b00, ovf, len, tot};
    assign m_axis_tlast = 1'b1;
endmodule

// ===== rtl/bsc_checker.sv =====
// Port-level checker for the bounded-spread run counter, with its bind.
`timescale 1ns / 1ps
module bsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:38] == 2'b00)
        else $error("fill bits set");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[36:24] <= 13'd4096)
        else $error("length out of range");
endmodule

bind bounded_spread_subarray_counter bsc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
